FILE: src/pit3_pkg.sv
// ---------------------------------------------------------------------------
// pit3_pkg: shared types and constants for the 3-D point-in-triangle core
// Beat payload structs, projection axis codes and default sizes.
// ---------------------------------------------------------------------------
package pit3_pkg;

  // Width of every coordinate field on the input port.
  localparam int IN_FIELD_W      = 16;
  // Default coordinate width used inside the core.
  localparam int COORD_WIDTH_DEF = 16;
  // Default depth of the queue between the front and back parts.
  localparam int QUEUE_DEPTH_DEF = 4;

  // Discarded projection axis.
  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;

  typedef struct packed {
    logic signed [IN_FIELD_W-1:0] a_x;
    logic signed [IN_FIELD_W-1:0] a_y;
    logic signed [IN_FIELD_W-1:0] a_z;
    logic signed [IN_FIELD_W-1:0] b_x;
    logic signed [IN_FIELD_W-1:0] b_y;
    logic signed [IN_FIELD_W-1:0] b_z;
    logic signed [IN_FIELD_W-1:0] c_x;
    logic signed [IN_FIELD_W-1:0] c_y;
    logic signed [IN_FIELD_W-1:0] c_z;
    logic signed [IN_FIELD_W-1:0] p_x;
    logic signed [IN_FIELD_W-1:0] p_y;
    logic signed [IN_FIELD_W-1:0] p_z;
  } item_t;

  typedef struct packed {
    logic       inside_res;
    logic       degenerate;
    logic [1:0] dropped_axis;
  } result_t;

endpackage

FILE: src/pit3_front.sv
// ---------------------------------------------------------------------------
// pit3_front: normal and projection axis classification
// Five-stage elastic pipeline: edge vectors, cross-product partial products,
// normal components, magnitudes, and the choice of the axis to drop.
// ---------------------------------------------------------------------------
module pit3_front #(
  parameter int COORD_WIDTH = pit3_pkg::COORD_WIDTH_DEF,
  parameter int ITEM_W      = 12 * COORD_WIDTH + 2
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  output logic                item_stall,
  input  pit3_pkg::item_t     item,
  output logic                cls_valid,
  input  logic                cls_stall,
  output logic [ITEM_W-1:0]   cls_item
);
  import pit3_pkg::*;

  localparam int W  = COORD_WIDTH;
  localparam int DW = W + 1;
  localparam int PW = 2 * W + 2;
  localparam int NW = 2 * W + 3;

  // Fields wider than the coordinate are cut; narrower ones are zero-extended.
  function automatic logic signed [W-1:0] to_coord(logic [IN_FIELD_W-1:0] f);
    logic [W-1:0] r;
    for (int i = 0; i < W; i++) begin
      r[i] = (i < IN_FIELD_W) ? f[i % IN_FIELD_W] : 1'b0;
    end
    return $signed(r);
  endfunction

  logic signed [W-1:0]  cin [12];
  logic signed [W-1:0]  c1 [12], c2 [12], c3 [12], c4 [12], c5 [12];
  logic signed [DW-1:0] u1 [3], w1 [3];
  logic signed [PW-1:0] p2 [6];
  logic signed [NW-1:0] n3 [3];
  logic        [NW-1:0] a4 [3];
  logic [1:0]           axis5;
  logic v1, v2, v3, v4, v5;
  logic rdy1, rdy2, rdy3, rdy4, rdy5;

  always_comb begin
    cin[0]  = to_coord(item.a_x);
    cin[1]  = to_coord(item.a_y);
    cin[2]  = to_coord(item.a_z);
    cin[3]  = to_coord(item.b_x);
    cin[4]  = to_coord(item.b_y);
    cin[5]  = to_coord(item.b_z);
    cin[6]  = to_coord(item.c_x);
    cin[7]  = to_coord(item.c_y);
    cin[8]  = to_coord(item.c_z);
    cin[9]  = to_coord(item.p_x);
    cin[10] = to_coord(item.p_y);
    cin[11] = to_coord(item.p_z);
  end

  assign rdy5 = !v5 || !cls_stall;
  assign rdy4 = !v4 || rdy5;
  assign rdy3 = !v3 || rdy4;
  assign rdy2 = !v2 || rdy3;
  assign rdy1 = !v1 || rdy2;
  assign item_stall = !rdy1;

  // u = A - B, w = C - B
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (rdy1) begin
      v1 <= item_valid;
    end
    if (rdy1 && item_valid) begin
      for (int k = 0; k < 12; k++) c1[k] <= cin[k];
      for (int k = 0; k < 3; k++) begin
        u1[k] <= DW'(cin[k]) - DW'(cin[3 + k]);
        w1[k] <= DW'(cin[6 + k]) - DW'(cin[3 + k]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (rdy2) begin
      v2 <= v1;
    end
    if (rdy2 && v1) begin
      for (int k = 0; k < 12; k++) c2[k] <= c1[k];
      p2[0] <= PW'(u1[1]) * PW'(w1[2]);
      p2[1] <= PW'(u1[2]) * PW'(w1[1]);
      p2[2] <= PW'(u1[2]) * PW'(w1[0]);
      p2[3] <= PW'(u1[0]) * PW'(w1[2]);
      p2[4] <= PW'(u1[0]) * PW'(w1[1]);
      p2[5] <= PW'(u1[1]) * PW'(w1[0]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (rdy3) begin
      v3 <= v2;
    end
    if (rdy3 && v2) begin
      for (int k = 0; k < 12; k++) c3[k] <= c2[k];
      for (int k = 0; k < 3; k++) n3[k] <= NW'(p2[2 * k]) - NW'(p2[2 * k + 1]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (rdy4) begin
      v4 <= v3;
    end
    if (rdy4 && v3) begin
      for (int k = 0; k < 12; k++) c4[k] <= c3[k];
      for (int k = 0; k < 3; k++) a4[k] <= n3[k][NW-1] ? NW'(-n3[k]) : NW'(n3[k]);
    end
  end

  // Largest magnitude wins; ties favour X, then Y.
  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else if (rdy5) begin
      v5 <= v4;
    end
    if (rdy5 && v4) begin
      for (int k = 0; k < 12; k++) c5[k] <= c4[k];
      priority if (a4[0] >= a4[1] && a4[0] >= a4[2]) begin
        axis5 <= AXIS_X;
      end else if (a4[1] >= a4[2]) begin
        axis5 <= AXIS_Y;
      end else begin
        axis5 <= AXIS_Z;
      end
    end
  end

  always_comb begin
    for (int k = 0; k < 12; k++) cls_item[k * W +: W] = c5[k];
    cls_item[12 * W +: 2] = axis5;
  end

  assign cls_valid = v5;

endmodule

FILE: src/pit3_queue.sv
// ---------------------------------------------------------------------------
// pit3_queue: small first-in first-out queue
// Decouples the classification pipeline from the projection pipeline.
// ---------------------------------------------------------------------------
module pit3_queue #(
  parameter int WIDTH = 64,
  parameter int DEPTH = pit3_pkg::QUEUE_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_valid,
  output logic             wr_stall,
  input  logic [WIDTH-1:0] wr_data,
  output logic             rd_valid,
  input  logic             rd_stall,
  output logic [WIDTH-1:0] rd_data
);
  import pit3_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;
  logic push, pop;

  assign wr_stall = (count == CNT_W'(DEPTH));
  assign rd_valid = (count != '0);
  assign push     = wr_valid && !wr_stall;
  assign pop      = rd_valid && !rd_stall;
  assign rd_data  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

FILE: src/pit3_back.sv
// ---------------------------------------------------------------------------
// pit3_back: projected barycentric sign test
// Six-stage elastic pipeline: projection and edge vectors, partial products,
// determinants, orientation fix-up, weight sum, and the final result register.
// ---------------------------------------------------------------------------
module pit3_back #(
  parameter int COORD_WIDTH = pit3_pkg::COORD_WIDTH_DEF,
  parameter int ITEM_W      = 12 * COORD_WIDTH + 2
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cls_valid,
  output logic                cls_stall,
  input  logic [ITEM_W-1:0]   cls_item,
  output logic                result_valid,
  input  logic                result_stall,
  output pit3_pkg::result_t   result
);
  import pit3_pkg::*;

  localparam int W  = COORD_WIDTH;
  localparam int DW = W + 1;
  localparam int PW = 2 * W + 2;
  localparam int NW = 2 * W + 3;
  localparam int SW = NW + 1;

  logic signed [W-1:0]  ci [12];
  logic [1:0]           axis_in;
  logic signed [W-1:0]  au, av, bu, bv, cu, cv, pu, pv;

  logic signed [DW-1:0] e1u, e1v, e2u, e2v, qu, qv;
  logic signed [PW-1:0] p2 [6];
  logic signed [NW-1:0] d3, n13, n23;
  logic signed [NW-1:0] d4, m14, m24;
  logic                 dg4;
  logic signed [NW-1:0] d5;
  logic signed [SW-1:0] s5;
  logic                 dg5, neg15, neg25;
  logic signed [SW-1:0] r6;
  logic [1:0] ax1, ax2, ax3, ax4, ax5;
  logic v1, v2, v3, v4, v5, v6;
  logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy6;

  always_comb begin
    for (int k = 0; k < 12; k++) ci[k] = $signed(cls_item[k * W +: W]);
    axis_in = cls_item[12 * W +: 2];
  end

  // Keep the two axes that remain after the drop, in cyclic order.
  always_comb begin
    unique case (axis_in)
      AXIS_Y: begin
        au = ci[2];  av = ci[0];  bu = ci[5];  bv = ci[3];
        cu = ci[8];  cv = ci[6];  pu = ci[11]; pv = ci[9];
      end
      AXIS_Z: begin
        au = ci[0];  av = ci[1];  bu = ci[3];  bv = ci[4];
        cu = ci[6];  cv = ci[7];  pu = ci[9];  pv = ci[10];
      end
      default: begin
        au = ci[1];  av = ci[2];  bu = ci[4];  bv = ci[5];
        cu = ci[7];  cv = ci[8];  pu = ci[10]; pv = ci[11];
      end
    endcase
  end

  assign rdy6 = !v6 || !result_stall;
  assign rdy5 = !v5 || rdy6;
  assign rdy4 = !v4 || rdy5;
  assign rdy3 = !v3 || rdy4;
  assign rdy2 = !v2 || rdy3;
  assign rdy1 = !v1 || rdy2;
  assign cls_stall = !rdy1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (rdy1) begin
      v1 <= cls_valid;
    end
    if (rdy1 && cls_valid) begin
      ax1 <= axis_in;
      e1u <= DW'(bu) - DW'(au);
      e1v <= DW'(bv) - DW'(av);
      e2u <= DW'(cu) - DW'(au);
      e2v <= DW'(cv) - DW'(av);
      qu  <= DW'(pu) - DW'(au);
      qv  <= DW'(pv) - DW'(av);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (rdy2) begin
      v2 <= v1;
    end
    if (rdy2 && v1) begin
      ax2   <= ax1;
      p2[0] <= PW'(e1u) * PW'(e2v);
      p2[1] <= PW'(e1v) * PW'(e2u);
      p2[2] <= PW'(qu) * PW'(e2v);
      p2[3] <= PW'(qv) * PW'(e2u);
      p2[4] <= PW'(e1u) * PW'(qv);
      p2[5] <= PW'(e1v) * PW'(qu);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (rdy3) begin
      v3 <= v2;
    end
    if (rdy3 && v2) begin
      ax3 <= ax2;
      d3  <= NW'(p2[0]) - NW'(p2[1]);
      n13 <= NW'(p2[2]) - NW'(p2[3]);
      n23 <= NW'(p2[4]) - NW'(p2[5]);
    end
  end

  // A clockwise winding is turned round so that the area is positive.
  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (rdy4) begin
      v4 <= v3;
    end
    if (rdy4 && v3) begin
      ax4 <= ax3;
      dg4 <= (d3 == '0);
      d4  <= d3[NW-1] ? -d3 : d3;
      m14 <= d3[NW-1] ? -n13 : n13;
      m24 <= d3[NW-1] ? -n23 : n23;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else if (rdy5) begin
      v5 <= v4;
    end
    if (rdy5 && v4) begin
      ax5   <= ax4;
      dg5   <= dg4;
      d5    <= d4;
      neg15 <= m14[NW-1];
      neg25 <= m24[NW-1];
      s5    <= SW'(m14) + SW'(m24);
    end
  end

  assign r6 = SW'(d5) - s5;

  always_ff @(posedge clk) begin
    if (rst) begin
      v6 <= 1'b0;
    end else if (rdy6) begin
      v6 <= v5;
    end
    if (rdy6 && v5) begin
      result.dropped_axis <= ax5;
      result.degenerate   <= dg5;
      result.inside_res   <= !dg5 && !neg15 && !neg25 && !r6[SW-1];
    end
  end

  assign result_valid = v6;

endmodule

FILE: src/point_in_triangle_3d_core.sv
// ---------------------------------------------------------------------------
// point_in_triangle_3d_core: exact 3-D point-in-triangle test
// Projects the triangle onto the plane of its dominant normal axis and tests
// the point with exact integer sign checks of the barycentric weights.
// ---------------------------------------------------------------------------
// The core takes one beat per clock cycle while item_stall is low, and
// returns one result beat for every input beat, in order. Each result passes
// through the registers of the classification pipeline, the queue and the
// projection pipeline, each pipeline stage holding one multiplier or one wide
// add on its path. A stalled output fills the back pipeline and then the
// queue, after which the input side stalls in turn; inputs keep flowing into
// the front part while the queue has room.
module point_in_triangle_3d_core #(
  parameter int COORD_WIDTH = pit3_pkg::COORD_WIDTH_DEF,
  parameter int QUEUE_DEPTH = pit3_pkg::QUEUE_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_stall,
  input  pit3_pkg::item_t   item,
  output logic              result_valid,
  input  logic              result_stall,
  output pit3_pkg::result_t result
);
  import pit3_pkg::*;

  // Each queued beat carries all twelve coordinates and the dropped axis.
  localparam int ITEM_W = 12 * COORD_WIDTH + 2;

  logic              f_valid, f_stall;
  logic [ITEM_W-1:0] f_item;
  logic              q_valid, q_stall;
  logic [ITEM_W-1:0] q_item;

  // Front part: forms the normal and chooses the axis to drop.
  pit3_front #(
    .COORD_WIDTH (COORD_WIDTH),
    .ITEM_W      (ITEM_W)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .item       (item),
    .cls_valid  (f_valid),
    .cls_stall  (f_stall),
    .cls_item   (f_item)
  );

  // The queue lets the front part run on while the output is held.
  pit3_queue #(
    .WIDTH (ITEM_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (f_valid),
    .wr_stall (f_stall),
    .wr_data  (f_item),
    .rd_valid (q_valid),
    .rd_stall (q_stall),
    .rd_data  (q_item)
  );

  // Back part: projects, forms the weights and registers the result.
  pit3_back #(
    .COORD_WIDTH (COORD_WIDTH),
    .ITEM_W      (ITEM_W)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .cls_valid    (q_valid),
    .cls_stall    (q_stall),
    .cls_item     (q_item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

`ifndef SYNTH
  // A degenerate triangle never reports the point as inside.
  a_degen_outside: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.degenerate |-> !result.inside_res)
    else $error("degenerate result reports inside");

  // The dropped axis is always one of the three real axes.
  a_axis_code: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result.dropped_axis == AXIS_X ||
                      result.dropped_axis == AXIS_Y ||
                      result.dropped_axis == AXIS_Z))
    else $error("invalid dropped axis code");

  // Reset empties every pipeline stage, so no result beat follows it.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result beat presented straight after reset");
`endif

endmodule

FILE: tb/tb.sv
// ---------------------------------------------------------------------------
// tb: self-checking bench for point_in_triangle_3d_core
// Drives triangle and point beats with random idling and back-pressure,
// predicts each verdict with exact integer sign tests and checks every
// result beat in order.
// ---------------------------------------------------------------------------
module tb;
  import pit3_pkg::*;

  // The core is built with its default coordinate width; the prediction
  // follows the same width so that masking and sign extension agree.
  localparam int CW           = COORD_WIDTH_DEF;
  localparam int RANDOM_ITEMS = 1200;
  // No idling at all once only this many input beats are left to send.
  localparam int QUIET_TAIL   = 150;
  // The core's latency with no back-pressure, plus a margin.
  localparam int DRAIN_CYCLES = 24;
  // A correct run sends 1221 beats; the limit below is set well beyond
  // the time that such a run needs.
  localparam int TIMEOUT      = 4_000_000;
  // Only the first mismatches are printed; all are counted.
  localparam int MAX_REPORTS  = 50;

  // A point with room for the arithmetic used when building stimulus.
  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
  } pt_t;

  logic    clk          = 1'b0;
  logic    rst          = 1'b1;
  logic    item_valid   = 1'b0;
  logic    item_stall;
  item_t   item         = '0;
  logic    result_valid;
  logic    result_stall = 1'b0;
  result_t result;

  // Triangles still to be sent, and verdicts predicted for beats already
  // taken by the core but not yet returned.
  item_t   tri_backlog[$];
  result_t verdict_fifo[$];

  int      total_items  = 0;
  int      items_taken  = 0;
  int      results_seen = 0;
  int      errors       = 0;
  int      cyc          = 0;
  int      src_gap      = 0;
  int      sink_gap     = 0;
  result_t want;
  logic    src_calm;
  logic    sink_calm;

  point_in_triangle_3d_core #(
    .COORD_WIDTH(CW)
  ) u_dut (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (item_valid),
    .item_stall  (item_stall),
    .item        (item),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result      (result)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // -------------------------------------------------------------------------
  // Prediction
  // -------------------------------------------------------------------------

  // Keep the low CW bits of a coordinate and sign-extend from bit CW-1.
  function automatic longint widen(input logic signed [IN_FIELD_W-1:0] raw);
    longint v;
    v = longint'(raw);
    v = v <<< (64 - CW);
    return v >>> (64 - CW);
  endfunction

  // The normal is (A-B) x (C-B). The axis of its largest magnitude is
  // dropped, ties going to X and then Y. In the remaining plane the point is
  // inside when both barycentric weights are non-negative and their sum is
  // at most one; this is decided on the numerators after the projected area
  // has been made positive, so no division is needed. Products stay well
  // inside 64 bits at 16-bit coordinates.
  function automatic result_t classify_triangle(input item_t t);
    longint va[3], vb[3], vc[3], vp[3];
    longint u[3], w[3];
    longint nx, ny, nz, mx, my, mz;
    longint e1u, e1v, e2u, e2v, qu, qv, area, n1, n2;
    int     iu, iv;
    result_t r;
    va = '{widen(t.a_x), widen(t.a_y), widen(t.a_z)};
    vb = '{widen(t.b_x), widen(t.b_y), widen(t.b_z)};
    vc = '{widen(t.c_x), widen(t.c_y), widen(t.c_z)};
    vp = '{widen(t.p_x), widen(t.p_y), widen(t.p_z)};
    for (int i = 0; i < 3; i++) begin
      u[i] = va[i] - vb[i];
      w[i] = vc[i] - vb[i];
    end
    nx = u[1] * w[2] - u[2] * w[1];
    ny = u[2] * w[0] - u[0] * w[2];
    nz = u[0] * w[1] - u[1] * w[0];
    mx = (nx < 0) ? -nx : nx;
    my = (ny < 0) ? -ny : ny;
    mz = (nz < 0) ? -nz : nz;
    if (mx >= my && mx >= mz) begin
      r.dropped_axis = AXIS_X;
      iu = 1;
      iv = 2;
    end else if (my >= mz) begin
      r.dropped_axis = AXIS_Y;
      iu = 2;
      iv = 0;
    end else begin
      r.dropped_axis = AXIS_Z;
      iu = 0;
      iv = 1;
    end
    e1u  = vb[iu] - va[iu];
    e1v  = vb[iv] - va[iv];
    e2u  = vc[iu] - va[iu];
    e2v  = vc[iv] - va[iv];
    qu   = vp[iu] - va[iu];
    qv   = vp[iv] - va[iv];
    area = e1u * e2v - e1v * e2u;
    n1   = qu * e2v - qv * e2u;
    n2   = e1u * qv - e1v * qu;
    // Winding must not matter, so flip everything to a positive area.
    if (area < 0) begin
      area = -area;
      n1   = -n1;
      n2   = -n2;
    end
    r.degenerate = (area == 0);
    r.inside_res = (area != 0) && (n1 >= 0) && (n2 >= 0) && (area - n1 - n2 >= 0);
    return r;
  endfunction

  // -------------------------------------------------------------------------
  // Stimulus helpers
  // -------------------------------------------------------------------------

  function automatic int span(input int lo, input int hi);
    return lo + int'($urandom_range(0, hi - lo));
  endfunction

  function automatic pt_t pt(input int x, input int y, input int z);
    pt_t r;
    r.x = x;
    r.y = y;
    r.z = z;
    return r;
  endfunction

  function automatic pt_t rand_pt(input int lo, input int hi);
    return pt(span(lo, hi), span(lo, hi), span(lo, hi));
  endfunction

  // a + k*d, used to place points exactly on a line.
  function automatic pt_t step_along(input pt_t a, input int k, input pt_t d);
    return pt(a.x + k * d.x, a.y + k * d.y, a.z + k * d.z);
  endfunction

  task automatic add_triangle(input pt_t a, input pt_t b, input pt_t c, input pt_t p);
    item_t t;
    t.a_x = a.x[IN_FIELD_W-1:0];
    t.a_y = a.y[IN_FIELD_W-1:0];
    t.a_z = a.z[IN_FIELD_W-1:0];
    t.b_x = b.x[IN_FIELD_W-1:0];
    t.b_y = b.y[IN_FIELD_W-1:0];
    t.b_z = b.z[IN_FIELD_W-1:0];
    t.c_x = c.x[IN_FIELD_W-1:0];
    t.c_y = c.y[IN_FIELD_W-1:0];
    t.c_z = c.z[IN_FIELD_W-1:0];
    t.p_x = p.x[IN_FIELD_W-1:0];
    t.p_y = p.y[IN_FIELD_W-1:0];
    t.p_z = p.z[IN_FIELD_W-1:0];
    tri_backlog.push_back(t);
  endtask

  task automatic flag_mismatch(input string what, input int seq,
                               input logic [3:0] got, input logic [3:0] exp_val);
    if (errors < MAX_REPORTS)
      $display("mismatch on result beat %0d, %s: got %b, wanted %b",
               seq, what, got, exp_val);
    errors++;
  endtask

  // -------------------------------------------------------------------------
  // Driver: presents queued triangles on the input channel. A burst of idle
  // cycles may start whenever the channel is free; a stalled beat is held
  // unchanged with valid high until the core takes it.
  // -------------------------------------------------------------------------
  always @(posedge clk) begin
    cyc <= cyc + 1;
  end

  // Idling stops in regular stretches, and for good near the end of the run.
  assign src_calm  = ((cyc / 200) % 4 == 3) || (items_taken + QUIET_TAIL >= total_items);
  assign sink_calm = ((cyc / 160) % 4 == 1) || (items_taken + QUIET_TAIL >= total_items);

  always @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
      src_gap    <= 0;
    end else if (!item_valid || !item_stall) begin
      if (src_gap != 0) begin
        src_gap    <= src_gap - 1;
        item_valid <= 1'b0;
      end else if (tri_backlog.size() == 0) begin
        item_valid <= 1'b0;
      end else if (!src_calm && $urandom_range(0, 5) == 0) begin
        // Start a burst of idle cycles with nothing on offer.
        src_gap    <= int'($urandom_range(0, 9));
        item_valid <= 1'b0;
      end else begin
        item       <= tri_backlog.pop_front();
        item_valid <= 1'b1;
      end
    end
  end

  // -------------------------------------------------------------------------
  // Monitor: watches both channels. A beat taken on the input side has its
  // verdict predicted and queued; a beat taken on the output side is checked
  // field by field against the oldest queued verdict. The monitor also plays
  // the receiver and stalls the result channel in random bursts.
  // -------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
      sink_gap     <= 0;
    end else begin
      if (result_valid && !result_stall) begin
        if (verdict_fifo.size() == 0) begin
          flag_mismatch("beat with no verdict outstanding", results_seen, result, 4'b0);
        end else begin
          want = verdict_fifo.pop_front();
          if (result.inside_res !== want.inside_res)
            flag_mismatch("inside_res", results_seen, 4'(result.inside_res),
                          4'(want.inside_res));
          if (result.degenerate !== want.degenerate)
            flag_mismatch("degenerate", results_seen, 4'(result.degenerate),
                          4'(want.degenerate));
          if (result.dropped_axis !== want.dropped_axis)
            flag_mismatch("dropped_axis", results_seen, 4'(result.dropped_axis),
                          4'(want.dropped_axis));
        end
        results_seen <= results_seen + 1;
      end
      if (item_valid && !item_stall) begin
        verdict_fifo.push_back(classify_triangle(item));
        items_taken <= items_taken + 1;
      end
      if (sink_gap != 0) begin
        sink_gap     <= sink_gap - 1;
        result_stall <= 1'b1;
      end else if (!sink_calm && $urandom_range(0, 5) == 0) begin
        sink_gap     <= int'($urandom_range(0, 9));
        result_stall <= 1'b1;
      end else begin
        result_stall <= 1'b0;
      end
    end
  end

  // -------------------------------------------------------------------------
  // Main sequence: build the stimulus, release reset, wait for every beat to
  // be taken and every verdict to come back, then give the verdict.
  // -------------------------------------------------------------------------
  initial begin
    pt_t  a, b, c, p, d;
    int   wa, wb, wc, sum, kind;
    item_t raw;

    // Directed part. Degenerate input with every coordinate zero: the normal
    // is zero, all components tie and X is dropped.
    add_triangle(pt(0, 0, 0), pt(0, 0, 0), pt(0, 0, 0), pt(0, 0, 0));
    // Triangle flat in XY, so Z is dropped; point inside, outside, on the
    // hypotenuse and on a corner.
    add_triangle(pt(0, 0, 0), pt(160, 0, 0), pt(0, 160, 0), pt(16, 16, 5));
    add_triangle(pt(0, 0, 0), pt(160, 0, 0), pt(0, 160, 0), pt(200, 200, 0));
    add_triangle(pt(0, 0, 0), pt(160, 0, 0), pt(0, 160, 0), pt(80, 80, 0));
    add_triangle(pt(0, 0, 0), pt(160, 0, 0), pt(0, 160, 0), pt(160, 0, -9));
    add_triangle(pt(0, 0, 0), pt(160, 0, 0), pt(0, 160, 0), pt(-1, 0, 0));
    // The same triangle wound the other way round must give the same answer.
    add_triangle(pt(0, 0, 0), pt(0, 160, 0), pt(160, 0, 0), pt(16, 16, 0));
    add_triangle(pt(0, 0, 0), pt(0, 160, 0), pt(160, 0, 0), pt(161, 0, 0));
    // Flat in YZ (X dropped) and in XZ (Y dropped).
    add_triangle(pt(0, 0, 0), pt(0, 160, 0), pt(0, 0, 160), pt(7, 20, 20));
    add_triangle(pt(0, 0, 0), pt(0, 0, 160), pt(160, 0, 0), pt(20, 3, 20));
    // Collinear vertices: zero normal, hence zero projected area.
    add_triangle(pt(0, 0, 0), pt(10, 10, 10), pt(20, 20, 20), pt(5, 5, 5));
    // Normal ties: X with Y goes to X, Y with Z goes to Y, all three to X.
    add_triangle(pt(0, 0, 0), pt(100, -100, 0), pt(0, 0, 100), pt(10, -10, 20));
    add_triangle(pt(0, 0, 0), pt(0, 100, -100), pt(100, 0, 0), pt(30, 40, -20));
    add_triangle(pt(100, 0, 0), pt(0, 100, 0), pt(0, 0, 100), pt(33, 33, 33));
    // Coordinates at the ends of their range.
    add_triangle(pt(-32768, -32768, -32768), pt(32767, -32768, 32767),
                 pt(-32768, 32767, 32767), pt(0, 0, 0));
    add_triangle(pt(-32768, -32768, -32768), pt(32767, -32768, 32767),
                 pt(-32768, 32767, 32767), pt(32767, 32767, -32768));
    add_triangle(pt(32767, 32767, 32767), pt(-32768, -32768, 32767),
                 pt(32767, -32768, -32768), pt(-32768, -32768, -32768));
    add_triangle(pt(32767, 32767, 32767), pt(-32768, -32768, 32767),
                 pt(32767, -32768, -32768), pt(32767, 32767, 32767));
    add_triangle(pt(32767, 32767, 32767), pt(32767, 32767, 32767),
                 pt(32767, 32767, 32767), pt(32767, 32767, 32767));
    add_triangle(pt(-32768, -32768, -32768), pt(-32768, -32768, -32768),
                 pt(-32768, -32768, -32768), pt(-32768, -32768, -32768));
    add_triangle(pt(-32768, 0, 0), pt(32767, 0, 0), pt(0, 32767, 0),
                 pt(-32768, 0, 32767));

    // Random part. Half the beats are shaped so that the point lands inside,
    // on an edge or on a corner; the rest are pure noise, collinear sets and
    // tiny triangles where ties and degenerate cases turn up often.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      kind = span(0, 9);
      case (kind)
        0, 1: begin
          raw = item_t'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
          tri_backlog.push_back(raw);
        end
        2, 3, 4: begin
          // Point as a weighted mix of the corners, so inside or very close.
          if ($urandom_range(0, 2) == 0) begin
            a = rand_pt(-64, 64);
            b = rand_pt(-64, 64);
            c = rand_pt(-64, 64);
          end else begin
            a = rand_pt(-32768, 32767);
            b = rand_pt(-32768, 32767);
            c = rand_pt(-32768, 32767);
          end
          wa  = span(0, 15);
          wb  = span(0, 15);
          wc  = span(0, 15);
          if (wa + wb + wc == 0)
            wa = 1;
          sum = wa + wb + wc;
          p   = pt((wa * a.x + wb * b.x + wc * c.x) / sum,
                   (wa * a.y + wb * b.y + wc * c.y) / sum,
                   (wa * a.z + wb * b.z + wc * c.z) / sum);
          add_triangle(a, b, c, p);
        end
        5, 6: begin
          // Point exactly on edge AB, corners included.
          a = rand_pt(-16000, 16000);
          d = rand_pt(-4000, 4000);
          b = step_along(a, 4, d);
          c = rand_pt(-32768, 32767);
          p = step_along(a, span(0, 4), d);
          add_triangle(a, b, c, p);
        end
        7: begin
          a = rand_pt(-8000, 8000);
          d = rand_pt(-2000, 2000);
          b = step_along(a, span(-4, 4), d);
          c = step_along(a, span(-4, 4), d);
          p = step_along(a, span(-4, 4), d);
          add_triangle(a, b, c, p);
        end
        default: begin
          add_triangle(rand_pt(-4, 4), rand_pt(-4, 4), rand_pt(-4, 4), rand_pt(-4, 4));
        end
      endcase
    end
    total_items = tri_backlog.size();

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    while (items_taken < total_items)
      @(posedge clk);
    while (verdict_fifo.size() != 0)
      @(posedge clk);
    // Let any stray beat show itself before the verdict.
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (errors == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

  // Watchdog: a hung handshake or a lost result beat ends up here.
  initial begin
    #(TIMEOUT);
    $display("status: fail");
    $finish;
  end

endmodule
